[rtl/owm_pkg.sv]
package owm_pkg;

  localparam int unsigned CfgW    = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitIdxW = 4;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] REG_RESET_LOW_TIME   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESENCE_WAIT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESET_RECOVERY   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHORT_LOW_TIME   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LONG_LOW_TIME    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_READ_SAMPLE_WAIT = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SLOT_LENGTH      = 3'd6;

  localparam logic [CfgW-1:0] DEF_RESET_LOW_TIME   = 10'd480;
  localparam logic [CfgW-1:0] DEF_PRESENCE_WAIT    = 10'd70;
  localparam logic [CfgW-1:0] DEF_RESET_RECOVERY   = 10'd410;
  localparam logic [CfgW-1:0] DEF_SHORT_LOW_TIME   = 10'd6;
  localparam logic [CfgW-1:0] DEF_LONG_LOW_TIME    = 10'd60;
  localparam logic [CfgW-1:0] DEF_READ_SAMPLE_WAIT = 10'd9;
  localparam logic [CfgW-1:0] DEF_SLOT_LENGTH      = 10'd70;

  localparam logic [ByteW-1:0]   CrcPoly = 8'h8C;
  localparam logic [BitIdxW-1:0] BitsPerByte = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_REC  = 3'd3,
    PH_BIT_LOW  = 3'd4,
    PH_WR_REL   = 3'd5,
    PH_RD_WAIT  = 3'd6,
    PH_RD_REST  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [CfgW-1:0] reset_low_time;
    logic [CfgW-1:0] presence_wait;
    logic [CfgW-1:0] reset_recovery;
    logic [CfgW-1:0] short_low_time;
    logic [CfgW-1:0] long_low_time;
    logic [CfgW-1:0] read_sample_wait;
    logic [CfgW-1:0] slot_length;
  } cfg_t;

  // one classified tick as queued between front and back
  typedef struct packed {
    logic             start;
    op_e              op;
    logic [ByteW-1:0] cmd_byte;
    logic             bus_level;
  } item_t;

  // reflected CRC-8, LSB first
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc_in,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] b;
    logic             mix;
    c = crc_in;
    b = data;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ b[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CrcPoly;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

[rtl/owm_in_if.sv]
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] mode;
  logic [7:0] cmd_byte;
  logic       bus_level;

  modport source(output valid, cmd_valid, mode, cmd_byte, bus_level, input ready);
  modport sink(input valid, cmd_valid, mode, cmd_byte, bus_level, output ready);
endinterface

[rtl/owm_out_if.sv]
interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;
  logic [7:0] crc_value;

  modport source(output valid, drive_low, busy_res, done_res, presence, read_data, crc_value,
                 input ready);
  modport sink(input valid, drive_low, busy_res, done_res, presence, read_data, crc_value,
               output ready);
endinterface

[rtl/owm_front.sv]
module owm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  owm_in_if.sink          req,
  output owm_pkg::item_t  item_o,
  output logic            item_valid_o,
  input  logic            item_ready_i
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  owm_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;
  owm_pkg::item_t  cls;

  // classify: only a legal mode on a command tick may start a sequence
  always_comb begin
    cls.start     = req.cmd_valid &&
                    (req.mode == owm_pkg::OP_RESET || req.mode == owm_pkg::OP_WRITE ||
                     req.mode == owm_pkg::OP_READ);
    cls.op        = owm_pkg::op_e'(req.mode);
    cls.cmd_byte  = req.cmd_byte;
    cls.bus_level = req.bus_level;
  end

  assign req.ready    = (cnt_q != CntW'(Depth));
  assign push         = req.valid && req.ready;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(Depth)) && !pop |=> cnt_q == CntW'(Depth))
    else $error("queue lost an entry while full");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(Depth)) |-> !req.ready)
    else $error("request accepted while queue full");

endmodule

[rtl/owm_back.sv]
module owm_back #(
  parameter int unsigned TimerBits = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  owm_pkg::cfg_t   cfg_i,
  input  owm_pkg::item_t  item_i,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  owm_out_if.source       rsp
);

  localparam int unsigned CfgW = owm_pkg::CfgW;
  localparam int unsigned LenW = ((TimerBits > CfgW) ? TimerBits : CfgW) + 1;
  localparam logic [LenW-1:0] TMax = LenW'((64'd1 << TimerBits) - 64'd1);

  function automatic logic [LenW-1:0] clip_len(input logic [LenW-1:0] v);
    logic [LenW-1:0] r;
    r = v;
    if (v == '0) begin
      r = LenW'(1);
    end else if (v > TMax) begin
      r = TMax;
    end
    return r;
  endfunction

  function automatic logic [LenW-1:0] slot_rest(input logic [LenW-1:0] slot,
                                                input logic [LenW-1:0] used);
    logic [LenW-1:0] r;
    r = (slot > used) ? slot - used : LenW'(1);
    return clip_len(r);
  endfunction

  owm_pkg::phase_e                 phase_q, phase_d, ph_cur;
  owm_pkg::op_e                    op_q, op_cur;
  logic [TimerBits-1:0]            timer_q, timer_d, tmr_cur, tmr_inc;
  logic [owm_pkg::BitIdxW-1:0]     bit_idx_q, bit_idx_d, bidx_cur, bidx_inc;
  logic [owm_pkg::ByteW-1:0]       shift_q, shift_d, shift_cur;
  logic [owm_pkg::ByteW-1:0]       crc_q, crc_d, crc_cur;
  logic [owm_pkg::ByteW-1:0]       last_rd_q, last_rd_d;
  logic                            pres_q, pres_d, pres_cur;

  logic                            rsp_valid_q;
  logic                            drive_q, busy_q, done_q;
  logic                            drive_d, busy_d, done_d;

  logic                            out_free, pop, start, expire, last_bit;
  logic [LenW-1:0]                 len_short, len_read, low_len, phase_len;

  assign out_free     = !rsp_valid_q || rsp.ready;
  assign pop          = item_valid_i && out_free;
  assign item_ready_o = out_free;

  // a command is taken only from idle; it starts its first phase on this tick
  assign start     = (phase_q == owm_pkg::PH_IDLE) && item_i.start;
  assign ph_cur    = !start ? phase_q :
                     (item_i.op == owm_pkg::OP_RESET) ? owm_pkg::PH_RST_LOW :
                                                         owm_pkg::PH_BIT_LOW;
  assign op_cur    = start ? item_i.op : op_q;
  assign tmr_cur   = start ? '0 : timer_q;
  assign tmr_inc   = tmr_cur + 1'b1;
  assign bidx_cur  = start ? '0 : bit_idx_q;
  assign bidx_inc  = bidx_cur + 1'b1;
  assign shift_cur = !start ? shift_q :
                     (item_i.op == owm_pkg::OP_WRITE) ? item_i.cmd_byte : '0;
  assign crc_cur   = (start && item_i.op == owm_pkg::OP_RESET) ? '0 : crc_q;
  assign pres_cur  = (start && item_i.op == owm_pkg::OP_RESET) ? 1'b0 : pres_q;

  assign len_short = clip_len(LenW'(cfg_i.short_low_time));
  assign len_read  = clip_len(LenW'(cfg_i.read_sample_wait));
  assign low_len   = (op_cur == owm_pkg::OP_WRITE && !shift_cur[0]) ?
                     clip_len(LenW'(cfg_i.long_low_time)) : len_short;

  always_comb begin
    case (ph_cur)
      owm_pkg::PH_RST_LOW:  phase_len = clip_len(LenW'(cfg_i.reset_low_time));
      owm_pkg::PH_RST_WAIT: phase_len = clip_len(LenW'(cfg_i.presence_wait));
      owm_pkg::PH_RST_REC:  phase_len = clip_len(LenW'(cfg_i.reset_recovery));
      owm_pkg::PH_BIT_LOW:  phase_len = low_len;
      owm_pkg::PH_WR_REL:   phase_len = slot_rest(LenW'(cfg_i.slot_length), low_len);
      owm_pkg::PH_RD_WAIT:  phase_len = len_read;
      default:              phase_len = slot_rest(LenW'(cfg_i.slot_length),
                                                  len_short + len_read);
    endcase
  end

  assign expire   = (ph_cur != owm_pkg::PH_IDLE) && (LenW'(tmr_inc) >= phase_len);
  assign last_bit = (bidx_inc >= owm_pkg::BitsPerByte);

  // next phase
  always_comb begin
    phase_d = ph_cur;
    if (expire) begin
      case (ph_cur)
        owm_pkg::PH_RST_LOW:  phase_d = owm_pkg::PH_RST_WAIT;
        owm_pkg::PH_RST_WAIT: phase_d = owm_pkg::PH_RST_REC;
        owm_pkg::PH_RST_REC:  phase_d = owm_pkg::PH_IDLE;
        owm_pkg::PH_BIT_LOW:  phase_d = (op_cur == owm_pkg::OP_WRITE) ?
                                        owm_pkg::PH_WR_REL : owm_pkg::PH_RD_WAIT;
        owm_pkg::PH_RD_WAIT:  phase_d = owm_pkg::PH_RD_REST;
        owm_pkg::PH_WR_REL,
        owm_pkg::PH_RD_REST:  phase_d = last_bit ? owm_pkg::PH_IDLE : owm_pkg::PH_BIT_LOW;
        default:              phase_d = owm_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath and tick outputs
  always_comb begin
    timer_d   = tmr_cur;
    bit_idx_d = bidx_cur;
    shift_d   = shift_cur;
    crc_d     = crc_cur;
    pres_d    = pres_cur;
    last_rd_d = last_rd_q;
    busy_d    = (ph_cur != owm_pkg::PH_IDLE);
    drive_d   = (ph_cur == owm_pkg::PH_RST_LOW) || (ph_cur == owm_pkg::PH_BIT_LOW);
    done_d    = 1'b0;
    if (ph_cur != owm_pkg::PH_IDLE) begin
      timer_d = expire ? '0 : tmr_inc;
    end
    if (expire) begin
      case (ph_cur)
        owm_pkg::PH_RST_WAIT: pres_d = !item_i.bus_level;
        owm_pkg::PH_RST_REC:  done_d = 1'b1;
        owm_pkg::PH_RD_WAIT:  shift_d = {item_i.bus_level, shift_cur[owm_pkg::ByteW-1:1]};
        owm_pkg::PH_WR_REL,
        owm_pkg::PH_RD_REST: begin
          if (op_cur == owm_pkg::OP_WRITE) begin
            shift_d = shift_cur >> 1;
          end
          bit_idx_d = bidx_inc;
          if (last_bit) begin
            done_d = 1'b1;
            if (op_cur == owm_pkg::OP_READ) begin
              last_rd_d = shift_cur;
              crc_d     = owm_pkg::crc8_byte(crc_cur, shift_cur);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= owm_pkg::PH_IDLE;
      op_q      <= owm_pkg::OP_RESET;
      timer_q   <= '0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      crc_q     <= '0;
      pres_q    <= 1'b0;
      last_rd_q <= '0;
    end else if (pop) begin
      phase_q   <= phase_d;
      op_q      <= op_cur;
      timer_q   <= timer_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      crc_q     <= crc_d;
      pres_q    <= pres_d;
      last_rd_q <= last_rd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (pop) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      drive_q <= drive_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign rsp.valid     = rsp_valid_q;
  assign rsp.drive_low = drive_q;
  assign rsp.busy_res  = busy_q;
  assign rsp.done_res  = done_q;
  assign rsp.presence  = pres_q;
  assign rsp.read_data = last_rd_q;
  assign rsp.crc_value = crc_q;

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (ph_cur != owm_pkg::PH_IDLE) && (phase_d == owm_pkg::PH_IDLE) |-> done_d)
    else $error("sequence ended without done");

  a_crc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && start && (item_i.op == owm_pkg::OP_RESET) |=> (crc_q == '0) && !pres_q)
    else $error("reset command did not clear crc and presence");

  a_bit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q <= owm_pkg::BitsPerByte)
    else $error("bit index ran past a byte");

  a_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == owm_pkg::PH_IDLE) && !item_i.start && pop |=> $stable(timer_q))
    else $error("timer moved while idle");

endmodule

[rtl/onewire_bus_master.sv]
// 1-Wire bus master. Each request on req_i is one timing tick (typically 1 us) carrying an
// optional command (reset, write byte, read byte), the byte to write and the sampled line
// level; each request yields exactly one response on rsp_o with the open-drain drive for
// that tick, busy/done flags, the last presence result, the last byte read and the running
// CRC-8 (reflected 0x8C) over bytes read since the last reset command. A valid frame read
// through its CRC byte leaves crc_value at zero. Commands arriving while a sequence runs
// are ignored. One tick is taken per clock cycle while rsp_o.ready is held high; a response
// passes through the two-entry input queue and then the sequencer step that loads the output
// register. Timing registers are written through cfg_* and apply from the next tick on, also
// in the middle of a command; change them only while no request is queued or waiting for
// its response.
module onewire_bus_master #(
  parameter int unsigned TimerBits = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [owm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [owm_pkg::CfgW-1:0]    cfg_data_i,
  owm_in_if.sink                      req_i,
  owm_out_if.source                   rsp_o
);

  owm_pkg::cfg_t  cfg_q, cfg_d;
  owm_pkg::item_t item;
  logic           item_valid, item_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        owm_pkg::REG_RESET_LOW_TIME:   cfg_d.reset_low_time   = cfg_data_i;
        owm_pkg::REG_PRESENCE_WAIT:    cfg_d.presence_wait    = cfg_data_i;
        owm_pkg::REG_RESET_RECOVERY:   cfg_d.reset_recovery   = cfg_data_i;
        owm_pkg::REG_SHORT_LOW_TIME:   cfg_d.short_low_time   = cfg_data_i;
        owm_pkg::REG_LONG_LOW_TIME:    cfg_d.long_low_time    = cfg_data_i;
        owm_pkg::REG_READ_SAMPLE_WAIT: cfg_d.read_sample_wait = cfg_data_i;
        owm_pkg::REG_SLOT_LENGTH:      cfg_d.slot_length      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time   <= owm_pkg::DEF_RESET_LOW_TIME;
      cfg_q.presence_wait    <= owm_pkg::DEF_PRESENCE_WAIT;
      cfg_q.reset_recovery   <= owm_pkg::DEF_RESET_RECOVERY;
      cfg_q.short_low_time   <= owm_pkg::DEF_SHORT_LOW_TIME;
      cfg_q.long_low_time    <= owm_pkg::DEF_LONG_LOW_TIME;
      cfg_q.read_sample_wait <= owm_pkg::DEF_READ_SAMPLE_WAIT;
      cfg_q.slot_length      <= owm_pkg::DEF_SLOT_LENGTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  owm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  owm_back #(
    .TimerBits (TimerBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .rsp          (rsp_o)
  );

endmodule
